>>> rtl/core/linear_probe_pointer_table_top_assert.svh
// Assertion macros for the pointer table block.
`ifndef LINEAR_PROBE_POINTER_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_POINTER_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LPPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lppt assertion failed");
`define LPPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lppt assertion failed");
`else
`define LPPT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPPT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/lppt_pkg.sv
// Shared types and constants for the pointer table.
package lppt_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [63:0] HashBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] HashMult = 64'h00000100000001B3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_MOVE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_RD, S_CHK, S_FIN, S_HASH2, S_RD2, S_CHK2, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic hash_start; // start hashing key (0) or new_key (1)
    logic hash_sel;
    logic rd;         // read slot at probe index
    logic step;       // advance probe index
    logic wr_live;    // write key/value and mark live at probe index
    logic wr_val;     // write value only at probe index
    logic mk_tomb;    // mark slot at probe index tombstone
    logic restore;    // mark saved slot live again
    logic save_hit;   // save probe index and value of hit
    logic set_res;    // latch result
    status_t res_st;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hash_done;
    logic is_empty;
    logic is_hit;
    logic exhausted;
    logic clearing;   // flag memory clearing pass after reset
    op_t  op;
  } sts_t;
endpackage

>>> rtl/core/lppt_ctrl.sv
// Controller state machine for the pointer table.
module lppt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic            out_busy,
  input  lppt_pkg::sts_t  sts,
  output lppt_pkg::cmd_t  cmd
);
  import lppt_pkg::*;
  `include "linear_probe_pointer_table_top_assert.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid && !sts.clearing) state_nxt = S_HASH;
      S_HASH:  if (sts.hash_done) state_nxt = S_RD;
      S_RD:    state_nxt = S_CHK;
      S_CHK: begin
        if (sts.is_hit || sts.is_empty || sts.exhausted) state_nxt = S_FIN;
        else state_nxt = S_RD;
      end
      S_FIN: begin
        if (sts.op == OP_MOVE && sts.is_hit) state_nxt = S_HASH2;
        else state_nxt = S_OUT;
      end
      S_HASH2: if (sts.hash_done) state_nxt = S_RD2;
      S_RD2:   state_nxt = S_CHK2;
      S_CHK2: begin
        if (sts.is_hit || sts.is_empty || sts.exhausted) state_nxt = S_OUT;
        else state_nxt = S_RD2;
      end
      S_OUT:   if (!out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_st = ST_OK;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = !sts.clearing;
        cmd.load = in_tvalid && !sts.clearing;
        cmd.hash_start = in_tvalid && !sts.clearing;
      end
      S_RD, S_RD2: cmd.rd = 1'b1;
      S_CHK: begin
        if (!(sts.is_hit || sts.is_empty || sts.exhausted)) cmd.step = 1'b1;
      end
      S_FIN: begin
        cmd.set_res = 1'b1;
        if (sts.exhausted && !sts.is_hit && !sts.is_empty) cmd.res_st = ST_FULL;
        else if (sts.op == OP_INSERT) begin
          if (sts.is_hit) cmd.wr_val = 1'b1;
          else cmd.wr_live = 1'b1;
        end else if (!sts.is_hit) cmd.res_st = ST_MISS;
        else if (sts.op == OP_REMOVE) begin
          cmd.save_hit = 1'b1;
          cmd.mk_tomb = 1'b1;
        end else if (sts.op == OP_MOVE) begin
          cmd.set_res = 1'b0;
          cmd.save_hit = 1'b1;
          cmd.mk_tomb = 1'b1;
          cmd.hash_start = 1'b1;
          cmd.hash_sel = 1'b1;
        end
      end
      S_CHK2: begin
        if (sts.is_hit || sts.is_empty || sts.exhausted) begin
          cmd.set_res = 1'b1;
          if (sts.is_hit) cmd.wr_val = 1'b1;
          else if (sts.is_empty) cmd.wr_live = 1'b1;
          else begin
            cmd.restore = 1'b1;
            cmd.res_st = ST_FULL;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  `LPPT_ASSERT_IMP(a_rdy_idle, clk, rst_n, in_tready, state_r == S_IDLE)
  `LPPT_ASSERT_IMP(a_one_write, clk, rst_n, cmd.wr_live, !cmd.wr_val)
  `LPPT_ASSERT_NXT(a_out_hold, clk, rst_n, state_r == S_OUT && out_busy, state_r == S_OUT)
endmodule

>>> rtl/core/lppt_dp.sv
// Datapath: hash unit, slot memories, flags and result register.
module lppt_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_op,
  input  logic [63:0]     in_key,
  input  logic [63:0]     in_new_key,
  input  logic [15:0]     in_entry_value,
  input  lppt_pkg::cmd_t  cmd,
  output lppt_pkg::sts_t  sts,
  input  logic            out_take,
  output logic            out_busy,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [9:0]      out_slot,
  output logic [15:0]     out_value
);
  import lppt_pkg::*;

  logic [1:0]  op_r;
  logic [63:0] key_r, nkey_r, hkey_r, h_r;
  logic [15:0] val_r, saved_v_r;
  logic [3:0]  hcnt_r;
  logic        hbusy_r, hdone_r, sel_r;
  logic [IdxW-1:0] idx_r, saved_i_r;
  logic [CntW-1:0] n_r;
  logic [63:0] kmem [Capacity];
  logic [15:0] vmem [Capacity];
  logic [1:0]  fmem [Capacity];  // {tombstone, occupied}
  logic [63:0] rd_key_r;
  logic [15:0] rd_val_r;
  logic occ_q_r, tomb_q_r;
  logic clr_busy_r;
  logic [IdxW-1:0] clr_idx_r;
  logic fl_we;
  logic [IdxW-1:0] fl_wa;
  logic [1:0] fl_wd;
  logic [63:0] cur_key, hx;
  logic [15:0] wval;

  assign cur_key = sel_r ? nkey_r : key_r;
  assign hx = h_r ^ {56'd0, hkey_r[7:0]};

  // hash: one byte per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hbusy_r <= 1'b0;
      hdone_r <= 1'b0;
    end else begin
      hdone_r <= hbusy_r && hcnt_r == 4'd7;
      if (cmd.hash_start) hbusy_r <= 1'b1;
      else if (hbusy_r && hcnt_r == 4'd7) hbusy_r <= 1'b0;
    end
    if (cmd.load) begin
      op_r <= in_op; key_r <= in_key; nkey_r <= in_new_key; val_r <= in_entry_value;
    end
    if (cmd.hash_start) begin
      hcnt_r <= '0;
      h_r <= HashBasis;
      hkey_r <= cmd.load ? in_key : nkey_r;
      sel_r <= cmd.hash_sel;
    end else if (hbusy_r) begin
      hcnt_r <= hcnt_r + 4'd1;
      // times HashMult = 2^40 + 0x1B3
      h_r <= (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4) + (hx << 1) + hx;
      hkey_r <= hkey_r >> 8;
    end
  end

  assign sts.hash_done = hdone_r;

  // probe index
  always_ff @(posedge clk) begin
    if (sts.hash_done) begin
      idx_r <= h_r[IdxW-1:0];
      n_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      n_r <= n_r + 1'b1;
    end
    if (cmd.rd) begin
      rd_key_r <= kmem[idx_r];
      rd_val_r <= vmem[idx_r];
      {tomb_q_r, occ_q_r} <= fmem[idx_r];
    end
  end

  assign sts.is_empty = !occ_q_r && !tomb_q_r;
  assign sts.is_hit = occ_q_r && rd_key_r == cur_key;
  assign sts.exhausted = n_r == CntW'(Capacity - 1);
  assign sts.op = op_t'(op_r);
  assign sts.clearing = clr_busy_r;

  assign wval = (op_r == OP_MOVE) ? saved_v_r : val_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_live) kmem[idx_r] <= cur_key;
    if (cmd.wr_live || cmd.wr_val) vmem[idx_r] <= wval;
    if (cmd.save_hit) begin
      saved_i_r <= idx_r;
      saved_v_r <= rd_val_r;
    end
  end

  // flag memory: cleared one slot per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IdxW'(Capacity - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_comb begin
    fl_we = 1'b0;
    fl_wa = idx_r;
    fl_wd = 2'b00;
    if (clr_busy_r) begin
      fl_we = 1'b1;
      fl_wa = clr_idx_r;
    end else if (cmd.wr_live) begin
      fl_we = 1'b1;
      fl_wd = 2'b01;
    end else if (cmd.mk_tomb) begin
      fl_we = 1'b1;
      fl_wd = 2'b10;
    end else if (cmd.restore) begin
      fl_we = 1'b1;
      fl_wa = saved_i_r;
      fl_wd = 2'b01;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_we) fmem[fl_wa] <= fl_wd;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.set_res) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
    if (cmd.set_res) begin
      out_status <= cmd.res_st;
      if (cmd.res_st != ST_OK) begin
        out_slot <= '0;
        out_value <= '0;
      end else begin
        out_slot <= 10'(idx_r);
        if (cmd.wr_live || cmd.wr_val) out_value <= wval;
        else out_value <= rd_val_r;
      end
    end
  end

  assign out_busy = out_valid && !out_take;
endmodule

>>> rtl/core/linear_probe_pointer_table_top.sv
// Top level of the linear probe pointer table.
// Open-addressing table of 64-bit keys with 16-bit values, 1024 slots.
// Input channel in_*: tdata = {entry_value, new_key, key, op}, one item per op.
// Result channel out_*: tdata = {result_value, slot, status}, one per item.
// Each item hashes its key with FNV-1a one byte per cycle, then walks the
// slot memory one probed slot at a time, reading then checking each, until a
// hit, an empty slot or a full sweep. A move that hits hashes its new key and
// probes a second time.
// One item is in flight at a time; in_tready is high only when idle, which is
// reached again in the cycle after the result is taken.
// After reset a clearing pass zeroes the slot flags with in_tready low. Key
// and value memories are not reset and are read only behind live flags.
// A stalled result is held in the output register; the block waits for it
// to be taken before returning to idle.
module linear_probe_pointer_table_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [151:0] in_tdata,  // op[1:0], key[65:2], new_key[129:66], entry_value[145:130]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata  // status[1:0], slot[11:2], result_value[27:12]
);
  import lppt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_busy;
  logic [1:0] st;
  logic [9:0] sl;
  logic [15:0] rv;

  lppt_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_busy, .sts, .cmd
  );

  lppt_dp u_dp (
    .clk, .rst_n,
    .in_op(in_tdata[1:0]),
    .in_key(in_tdata[65:2]),
    .in_new_key(in_tdata[129:66]),
    .in_entry_value(in_tdata[145:130]),
    .cmd, .sts,
    .out_take(out_tready),
    .out_busy,
    .out_valid(out_tvalid),
    .out_status(st),
    .out_slot(sl),
    .out_value(rv)
  );

  assign out_tdata = {4'd0, rv, sl, st};
endmodule
